FILE: src/nfa_pkg.sv
// Shared types and codes of the NFA string recognizer.
package nfa_pkg;

    localparam int DEF_MAX_STATES = 32;
    localparam int DEF_MAX_EDGES  = 128;

    localparam int STATE_W = 5;
    localparam int SYM_W   = 8;
    localparam int INDEX_W = 7;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_START  = 2'd1;
    localparam logic [OP_W-1:0] OP_SYMBOL = 2'd2;

    localparam logic [0:0] CFG_NUM_STATES = 1'b0;
    localparam logic [0:0] CFG_NUM_EDGES  = 1'b1;

    typedef struct packed {
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   edge_symbol;
        logic [STATE_W-1:0] to_state;
    } t_edge;

endpackage

FILE: src/nfa_edge_ram.sv
// Edge table memory: one write port, one read port with registered data.
module nfa_edge_ram
    import nfa_pkg::*;
#(
    parameter int MAX_EDGES = DEF_MAX_EDGES,
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_edge         i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_edge         o_rd_data
);

    t_edge r_mem [MAX_EDGES];
    t_edge r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/nfa_string_recognizer.sv
// NFA string recognizer: active-state set driven by a walk of the edge table memory.
//
// Each request carries an operation: load one edge entry, start a new string (only state 0
// active), or feed one symbol byte; every request returns one result with accepted (highest
// state in use is active) and alive (any state in use is active). A symbol request walks the
// edge table from entry 0 up to min(num_edges, MAX_EDGES)-1, one memory read per cycle, so it
// occupies the block until the walk ends and its result is posted; load, start and unused
// operations skip the walk and go straight to the finish state. Edge entries below
// num_edges must be loaded before symbols are fed.
module nfa_string_recognizer
    import nfa_pkg::*;
#(
    parameter int MAX_STATES = DEF_MAX_STATES,
    parameter int MAX_EDGES  = DEF_MAX_EDGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // edge_index[6:0], from_state[11:7], edge_symbol[19:12], to_state[24:20],
    // symbol[32:25], zero pad[39:33]
    input  logic [39:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], alive[1], zero pad[7:2]
    output logic [7:0]  m_axis_tdata
);

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int NW = $clog2(MAX_STATES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // unpacked request fields
    logic [OP_W-1:0]    in_operation;
    logic [INDEX_W-1:0] in_edge_index;
    t_edge              in_edge;
    logic [SYM_W-1:0]   in_symbol;

    assign in_operation         = s_axis_tuser;
    assign in_edge_index        = s_axis_tdata[6:0];
    assign in_edge.from_state   = s_axis_tdata[11:7];
    assign in_edge.edge_symbol  = s_axis_tdata[19:12];
    assign in_edge.to_state     = s_axis_tdata[24:20];
    assign in_symbol            = s_axis_tdata[32:25];

    logic [5:0]            r_num_states;
    logic [7:0]            r_num_edges;
    logic [1:0]            r_state;
    logic [MAX_STATES-1:0] r_active;
    logic [MAX_STATES-1:0] r_cur;
    logic [MAX_STATES-1:0] r_next;
    logic [MAX_STATES-1:0] n_next;
    logic [CW-1:0]         r_issue;
    logic [CW-1:0]         r_ne;
    logic                  r_rd_vld;
    logic [SYM_W-1:0]      r_sym;
    logic                  r_m_valid;
    logic                  r_accepted;
    logic                  r_alive;

    logic [NW-1:0]         n_use;
    logic [MAX_STATES-1:0] mask;
    logic [MAX_STATES-1:0] last_bit;
    logic [CW-1:0]         ne_use;
    logic                  in_acc;
    logic                  out_free;
    logic                  load_ok;
    logic                  rd_en;
    t_edge                 rd_edge;
    logic                  src_hit;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_m_valid || m_axis_tready;
    assign load_ok  = in_acc && (in_operation == OP_LOAD) && (32'(in_edge_index) < MAX_EDGES);
    assign rd_en    = (r_state == ST_WALK) && (r_issue < r_ne);

    // clamp register values to the supported range
    always_comb begin
        if (r_num_states == 6'd0) begin
            n_use = NW'(1);
        end else if (32'(r_num_states) > MAX_STATES) begin
            n_use = NW'(MAX_STATES);
        end else begin
            n_use = NW'(r_num_states);
        end
        if (32'(r_num_edges) > MAX_EDGES) begin
            ne_use = CW'(MAX_EDGES);
        end else begin
            ne_use = CW'(r_num_edges);
        end
        for (int s = 0; s < MAX_STATES; s++) begin
            mask[s]     = (s < int'(n_use));
            last_bit[s] = (s == int'(n_use) - 1);
        end
    end

    nfa_edge_ram #(
        .MAX_EDGES(MAX_EDGES)
    ) u_edge_ram (
        .i_clk     (i_clk),
        .i_wr_en   (load_ok),
        .i_wr_addr (AW'(in_edge_index)),
        .i_wr_data (in_edge),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issue[AW-1:0]),
        .o_rd_data (rd_edge)
    );

    // merge the targets of one edge read from the table
    always_comb begin
        src_hit = 1'b0;
        for (int s = 0; s < MAX_STATES; s++) begin
            if (int'(rd_edge.from_state) == s && r_cur[s]) begin
                src_hit = 1'b1;
            end
        end
        n_next = r_next;
        if (r_rd_vld && src_hit && (rd_edge.edge_symbol == r_sym)) begin
            for (int s = 0; s < MAX_STATES; s++) begin
                if (int'(rd_edge.to_state) == s && mask[s]) begin
                    n_next[s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_states <= 6'd1;
            r_num_edges  <= 8'd0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_NUM_STATES: r_num_states <= i_cfg_wdata[5:0];
                CFG_NUM_EDGES:  r_num_edges  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // post a result on finish, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_active  <= MAX_STATES'(1);
            r_rd_vld  <= 1'b0;
            r_issue   <= '0;
            r_ne      <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (in_operation)
                            OP_START: begin
                                r_active <= MAX_STATES'(1);
                                r_state  <= ST_FIN;
                            end
                            OP_SYMBOL: begin
                                r_state <= ST_WALK;
                                r_cur   <= r_active & mask;
                                r_next  <= '0;
                                r_sym   <= in_symbol;
                                r_ne    <= ne_use;
                                r_issue <= '0;
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_WALK: begin
                    r_next   <= n_next;
                    r_rd_vld <= rd_en;
                    if (rd_en) begin
                        r_issue <= r_issue + CW'(1);
                    end else if (!r_rd_vld) begin
                        // all entries merged: commit the new set
                        r_active <= r_next;
                        r_state  <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_accepted <= |(r_active & last_bit);
                        r_alive    <= |(r_active & mask);
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_alive, r_accepted};

    // no table read is in flight while requests are taken
    a_idle_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !r_rd_vld)
        else $error("edge read pending while idle");

    // the walk never issues past the captured edge count
    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_issue <= r_ne))
        else $error("edge walk overran the edge count");

    // a symbol request starts a walk
    a_symbol_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_operation == OP_SYMBOL)) |=> (r_state == ST_WALK))
        else $error("symbol request did not start a walk");

    // a result leaves the finish state only into a full output register
    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FIN) && out_free) |=> (r_m_valid && (r_state == ST_IDLE)))
        else $error("result not posted on finish");

endmodule

FILE: verif/nfa_result_checker.sv
`timescale 1ns / 100ps
// Result checker: predicts accept/alive verdicts from accepted requests and compares results.
module nfa_result_checker
    import nfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [39:0] i_req_data,
    input  logic [1:0]  i_req_user,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [7:0]  i_res_data,
    output int          o_pending,
    output int          o_errors
);

    // request layout on the stream, highest field first
    typedef struct packed {
        logic [6:0]         pad;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
        logic [SYM_W-1:0]   edge_symbol;
        logic [STATE_W-1:0] from_state;
        logic [INDEX_W-1:0] edge_index;
    } t_request;

    typedef struct packed {
        logic alive;
        logic accepted;
    } t_verdict;

    logic [5:0]                states_reg;
    logic [7:0]                edges_reg;
    logic [DEF_MAX_STATES-1:0] active_states;
    t_edge                     edge_mem [DEF_MAX_EDGES];
    t_verdict                  verdicts_due [$];
    int                        errors = 0;

    function automatic t_verdict advance_nfa(t_request req, logic [OP_W-1:0] op);
        int                        n_used;
        int                        e_used;
        logic [DEF_MAX_STATES-1:0] in_use;
        logic [DEF_MAX_STATES-1:0] live;
        logic [DEF_MAX_STATES-1:0] next_set;
        t_verdict                  v;
        n_used = (states_reg == 0) ? 1 :
                 (states_reg > DEF_MAX_STATES) ? DEF_MAX_STATES : int'(states_reg);
        e_used = (edges_reg > DEF_MAX_EDGES) ? DEF_MAX_EDGES : int'(edges_reg);
        in_use = '0;
        for (int s = 0; s < n_used; s++) in_use[s] = 1'b1;
        case (op)
            OP_LOAD: begin
                edge_mem[req.edge_index] = {req.from_state, req.edge_symbol, req.to_state};
            end
            OP_START: begin
                active_states = DEF_MAX_STATES'(1);
            end
            OP_SYMBOL: begin
                live = active_states & in_use;
                next_set = '0;
                for (int e = 0; e < e_used; e++) begin
                    // drop edges that lead to states outside the count in use
                    if (live[edge_mem[e].from_state] && edge_mem[e].edge_symbol == req.symbol
                            && edge_mem[e].to_state < n_used)
                        next_set[edge_mem[e].to_state] = 1'b1;
                end
                active_states = next_set;
            end
            default: ;
        endcase
        v.accepted = active_states[n_used-1];
        v.alive    = |(active_states & in_use);
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict due;
        if (!i_rst_n) begin
            states_reg    = 6'd1;
            edges_reg     = '0;
            active_states = DEF_MAX_STATES'(1);
            verdicts_due.delete();
            for (int e = 0; e < DEF_MAX_EDGES; e++) edge_mem[e] = '0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_addr == CFG_NUM_STATES)
                    states_reg = i_cfg_wdata[5:0];
                else
                    edges_reg = i_cfg_wdata;
            end
            // match results before queuing this cycle's request
            if (i_res_valid && i_res_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    errors++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (i_res_data[0] !== due.accepted) begin
                        $error("accepted: expected %0b, got %0b", due.accepted, i_res_data[0]);
                        errors++;
                    end
                    if (i_res_data[1] !== due.alive) begin
                        $error("alive: expected %0b, got %0b", due.alive, i_res_data[1]);
                        errors++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                verdicts_due.push_back(advance_nfa(i_req_data, i_req_user));
        end
        o_pending <= verdicts_due.size();
        o_errors  <= errors;
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top level: drives requests and register writes into the NFA recognizer and gives the verdict.
module testbench;
    import nfa_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RUN_LIMIT      = 1_500_000;
    localparam int HOLD_CYCLES    = 300;
    localparam int ITEMS_PER_MODE = 480;
    localparam int DRAIN_CYCLES   = 140;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [0:0]  i_cfg_addr = '0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;

    int   pending;
    int   fail_count;
    int   sent = 0;
    int   cycles = 0;
    int   mode = 0;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    always #4 i_clk = ~i_clk;

    nfa_string_recognizer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    nfa_result_checker verdict_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (s_axis_tvalid),
        .i_req_ready (s_axis_tready),
        .i_req_data  (s_axis_tdata),
        .i_req_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .o_pending   (pending),
        .o_errors    (fail_count)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // edge_index[6:0], from_state[11:7], edge_symbol[19:12], to_state[24:20],
    // symbol[32:25], zero pad[39:33]
    function automatic logic [39:0] req_word(logic [INDEX_W-1:0] idx,
                                             logic [STATE_W-1:0] from, logic [SYM_W-1:0] esym,
                                             logic [STATE_W-1:0] to, logic [SYM_W-1:0] sym);
        return {7'b0, sym, to, esym, from, idx};
    endfunction

    // keep tvalid high across back-to-back requests; lower it only for a gap
    task automatic send_req(input logic [OP_W-1:0] op, input logic [39:0] req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= req;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic load_edge(input int idx, input int from, input int esym, input int to);
        send_req(OP_LOAD, req_word(7'(idx), 5'(from), 8'(esym), 5'(to), 8'($urandom)));
    endtask

    task automatic feed(input int sym);
        send_req(OP_SYMBOL, req_word(7'($urandom), 5'($urandom), 8'($urandom), 5'($urandom),
                                     8'(sym)));
    endtask

    task automatic send_op(input logic [OP_W-1:0] op);
        send_req(op, req_word(7'($urandom), 5'($urandom), 8'($urandom), 5'($urandom),
                              8'($urandom)));
    endtask

    // mostly edges inside the states in use; now and then a target beyond them
    task automatic load_random_edge(input int idx, input int n_states, input int sym);
        int to;
        to = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(n_states - 1);
        load_edge(idx, $urandom_range(n_states - 1), sym, to);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [0:0] addr, input logic [7:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // one automaton over a small alphabet, then several strings with some noise
    task automatic run_session(input int forced_edges);
        int         n_states;
        int         n_edges;
        int         rows;
        int         len;
        int         r;
        logic [7:0] alphabet [3];
        logic [7:0] states_val;
        for (int a = 0; a < 3; a++) alphabet[a] = 8'($urandom);
        r = $urandom_range(99);
        if (r < 10)
            n_states = 32;
        else if (r < 55)
            n_states = $urandom_range(1, 6);
        else
            n_states = $urandom_range(1, 32);
        if (forced_edges >= 0) begin
            n_edges = forced_edges;
        end else begin
            r = $urandom_range(99);
            if (r < 80)
                n_edges = $urandom_range(1, 16);
            else if (r < 95)
                n_edges = $urandom_range(17, 128);
            else if (r < 97)
                n_edges = 0;
            else
                n_edges = $urandom_range(129, 255);
        end
        rows = (n_edges > DEF_MAX_EDGES) ? DEF_MAX_EDGES : n_edges;
        for (int e = 0; e < rows; e++)
            load_random_edge(e, n_states, alphabet[$urandom_range(2)]);
        drain();
        states_val = 8'(n_states);
        if (n_states == 1 && $urandom_range(3) == 0)
            states_val = 8'd0;
        else if (n_states == 32 && $urandom_range(2) == 0)
            states_val = 8'($urandom_range(33, 63)) | ($urandom_range(1) ? 8'hC0 : 8'h00);
        write_cfg(CFG_NUM_STATES, states_val);
        write_cfg(CFG_NUM_EDGES, 8'(n_edges));
        if (mode == 2 && !hold_req) hold_req = 1'b1;
        repeat ($urandom_range(2, 6)) begin
            send_op(OP_START);
            len = $urandom_range(0, 10);
            repeat (len) begin
                r = $urandom_range(99);
                if (r < 6)
                    send_op(OP_UNUSED);
                else if (r < 10)
                    load_random_edge(rows > 0 ? $urandom_range(rows - 1) : $urandom_range(127),
                                     n_states, alphabet[$urandom_range(2)]);
                else if (r < 22)
                    feed($urandom_range(255));
                else
                    feed(alphabet[$urandom_range(2)]);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 31;
        rx_idle_pct = 74;

        // no edges in use: the set dies and stays dead
        feed(8'hFF);
        feed(8'h00);
        send_op(OP_UNUSED);
        send_op(OP_START);
        load_edge(0, 0, 8'h00, 31);
        load_edge(1, 31, 8'hFF, 0);
        load_edge(2, 0, 8'h00, 1);
        load_edge(127, 31, 8'hAA, 31);
        drain();
        write_cfg(CFG_NUM_STATES, 8'd32);
        write_cfg(CFG_NUM_EDGES, 8'd3);
        send_op(OP_START);
        feed(8'h00);
        feed(8'hFF);
        feed(8'h55);
        feed(8'h00);
        // zero states acts as one: both targets fall outside
        drain();
        write_cfg(CFG_NUM_STATES, 8'd0);
        send_op(OP_START);
        feed(8'h00);
        // masked to 63, acts as the full state count
        drain();
        write_cfg(CFG_NUM_STATES, 8'hFF);
        send_op(OP_START);
        feed(8'h00);
        send_op(OP_UNUSED);
        load_edge(3, 31, 8'h00, 0);
        feed(8'h00);
        drain();

        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin tx_idle_pct = 31; rx_idle_pct = 74; end
                1: begin tx_idle_pct = 74; rx_idle_pct = 31; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            // open the first two modes with a full table once
            run_session(mode == 0 ? 255 : (mode == 1 ? 128 : -1));
            while (sent < 20 + (mode + 1) * ITEMS_PER_MODE) run_session(-1);
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: nfa_string_recognizer.f
src/nfa_pkg.sv
src/nfa_edge_ram.sv
src/nfa_string_recognizer.sv
verif/nfa_result_checker.sv
verif/testbench.sv
